// ===== hw/rtl/smd_pkg.sv =====
// smd_pkg: phases, result kinds, magic word and result struct for the
// message deframer. No dependencies.
`timescale 1ns / 1ps

package smd_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC   = 4'd0,
    PH_SIZE    = 4'd1,
    PH_OPCODE  = 4'd2,
    PH_PATHLEN = 4'd3,
    PH_PATH    = 4'd4,
    PH_BODYLEN = 4'd5,
    PH_BODY    = 4'd6,
    PH_MTIME   = 4'd7,
    PH_HALT    = 4'd8
  } phase_t;

  typedef logic [2:0] kind_t;

  localparam kind_t K_SIZE     = 3'd0;
  localparam kind_t K_OPCODE   = 3'd1;
  localparam kind_t K_PATHLEN  = 3'd2;
  localparam kind_t K_PATHBYTE = 3'd3;
  localparam kind_t K_BODYLEN  = 3'd4;
  localparam kind_t K_BODYBYTE = 3'd5;
  localparam kind_t K_MTIME    = 3'd6;
  localparam kind_t K_BADMAGIC = 3'd7;

  localparam logic [31:0] MAGIC_WORD = 32'h5656_5332;
  localparam logic [2:0]  LEN_WORD32 = 3'd4;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] value;
    logic        msg_end;
  } result_t;

endpackage

// ===== hw/rtl/smd_if.sv =====
// Valid/ready channel interfaces for the deframer: byte input and result output.
// No dependencies.
`timescale 1ns / 1ps

interface smd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface smd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  item_kind;
  logic [63:0] item_value;
  logic        message_end;

  modport source (output valid, output item_kind, output item_value, output message_end,
                  input ready);
  modport sink   (input valid, input item_kind, input item_value, input message_end,
                  output ready);
endinterface

// ===== hw/rtl/smd_parser.sv =====
// smd_parser: message phase tracker, field accumulator and payload counter.
// Decodes one byte per accepted beat into at most one result. Depends on smd_pkg.
`timescale 1ns / 1ps

module smd_parser
  import smd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] data_byte,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] rem_r, rem_nxt;

  logic [63:0] acc_shift;
  logic [2:0]  idx_inc;
  logic [31:0] rem_dec;
  logic        word_done;
  logic        magic_bad;

  assign acc_shift = {acc_r[55:0], data_byte};
  assign idx_inc   = idx_r + 3'd1;
  assign rem_dec   = rem_r - 32'd1;
  assign word_done = (idx_inc == LEN_WORD32);
  assign magic_bad = (acc_shift[31:0] != MAGIC_WORD);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    case (phase_r)
      PH_MAGIC, PH_PATHLEN, PH_BODYLEN: begin
        acc_nxt = acc_shift;
        idx_nxt = idx_inc;
        if (word_done) begin
          idx_nxt = 3'd0;
          acc_nxt = 64'd0;
          if (phase_r == PH_MAGIC) begin
            phase_nxt = magic_bad ? PH_HALT : PH_SIZE;
          end else begin
            rem_nxt = acc_shift[31:0];
            if (phase_r == PH_PATHLEN) begin
              phase_nxt = (acc_shift[31:0] == 32'd0) ? PH_BODYLEN : PH_PATH;
            end else begin
              phase_nxt = (acc_shift[31:0] == 32'd0) ? PH_MTIME : PH_BODY;
            end
          end
        end
      end
      PH_SIZE, PH_MTIME: begin
        acc_nxt = acc_shift;
        idx_nxt = idx_inc;
        if (idx_inc == 3'd0) begin
          acc_nxt   = 64'd0;
          phase_nxt = (phase_r == PH_SIZE) ? PH_OPCODE : PH_MAGIC;
        end
      end
      PH_OPCODE: phase_nxt = PH_PATHLEN;
      PH_PATH, PH_BODY: begin
        rem_nxt = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_nxt = (phase_r == PH_PATH) ? PH_BODYLEN : PH_MTIME;
        end
      end
      default: phase_nxt = PH_HALT;
    endcase
  end

  // outputs
  always_comb begin
    res_valid   = 1'b0;
    res.kind    = K_SIZE;
    res.value   = {56'd0, data_byte};
    res.msg_end = 1'b0;
    case (phase_r)
      PH_MAGIC: begin
        res_valid = word_done && magic_bad;
        res.kind  = K_BADMAGIC;
        res.value = {32'd0, acc_shift[31:0]};
      end
      PH_SIZE: begin
        res_valid = (idx_inc == 3'd0);
        res.kind  = K_SIZE;
        res.value = acc_shift;
      end
      PH_OPCODE: begin
        res_valid = 1'b1;
        res.kind  = K_OPCODE;
      end
      PH_PATHLEN: begin
        res_valid = word_done;
        res.kind  = K_PATHLEN;
        res.value = {32'd0, acc_shift[31:0]};
      end
      PH_PATH: begin
        res_valid = 1'b1;
        res.kind  = K_PATHBYTE;
      end
      PH_BODYLEN: begin
        res_valid = word_done;
        res.kind  = K_BODYLEN;
        res.value = {32'd0, acc_shift[31:0]};
      end
      PH_BODY: begin
        res_valid = 1'b1;
        res.kind  = K_BODYBYTE;
      end
      PH_MTIME: begin
        res_valid   = (idx_inc == 3'd0);
        res.kind    = K_MTIME;
        res.value   = acc_shift;
        res.msg_end = 1'b1;
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC;
      idx_r   <= 3'd0;
      acc_r   <= 64'd0;
      rem_r   <= 32'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

// ===== hw/rtl/smd_out_stage.sv =====
// smd_out_stage: result register driving the output channel.
// Depends on smd_pkg and smd_if.
`timescale 1ns / 1ps

module smd_out_stage
  import smd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  result_t   res,
  output logic      free,
  smd_out_if.source out_chan
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign free = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.item_kind   = res_r.kind;
  assign out_chan.item_value  = res_r.value;
  assign out_chan.message_end = res_r.msg_end;

endmodule

// ===== hw/rtl/sync_message_deframer_core.sv =====
// Top level of the sync message deframer: byte input channel, parser, result register.
// Depends on smd_pkg, smd_if, smd_parser and smd_out_stage.
// Takes one message byte per beat and parses magic "VVS2", 8-byte size, opcode,
// 4-byte path length, path bytes, 4-byte body length, body bytes and 8-byte mtime,
// all big-endian. Each completed field after a good magic and each payload byte gives
// one result beat; the mtime beat carries message_end. A wrong magic gives one
// bad-magic beat, then all later bytes are dropped until reset. One byte is accepted
// every cycle unless a held result is stalled by the output side, the only time input
// ready is low; the single result register shows a result in the cycle after its byte.
`timescale 1ns / 1ps

module sync_message_deframer_core
  import smd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  smd_in_if.sink    in_chan,
  smd_out_if.source out_chan
);

  logic    take;
  logic    free;
  logic    res_valid;
  result_t res;

  assign in_chan.ready = free;
  assign take          = in_chan.valid && free;

  smd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_chan.data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  smd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take && res_valid),
    .res      (res),
    .free     (free),
    .out_chan (out_chan)
  );

endmodule

// ===== hw/rtl/smd_checker.sv =====
// smd_checker: port-level assertions for sync_message_deframer_core, and its bind.
// Depends on smd_pkg.
`timescale 1ns / 1ps

module smd_checker
  import smd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  item_kind,
  input logic [63:0] item_value,
  input logic        message_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(item_kind)
      && $stable(item_value) && $stable(message_end)))
    else $error("stalled result beat changed");

  a_end_mtime: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (message_end == (item_kind == K_MTIME)))
    else $error("message_end not tied to mtime beat");

  a_beat_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result beat without input beat");

  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sync_message_deframer_core smd_checker u_smd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .item_kind   (out_chan.item_kind),
  .item_value  (out_chan.item_value),
  .message_end (out_chan.message_end)
);

// ===== test/tb_sync_message_deframer_core.sv =====
// Testbench for sync_message_deframer_core: sends framed messages byte by byte and
// checks every result beat against a predictor kept in step with the input.
// Depends on smd_pkg, smd_if and the deframer RTL.
`timescale 1ns / 1ps

module tb_sync_message_deframer_core;
  import smd_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_BYTES  = 1200;
  localparam int DRAIN_CYCLES  = 8;

  logic clk;
  logic rst_n;

  smd_in_if  in_ch();
  smd_out_if out_ch();

  sync_message_deframer_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  // predictor state
  phase_t      dfr_phase;
  logic [2:0]  dfr_idx;
  logic [63:0] dfr_acc;
  logic [31:0] dfr_left;

  result_t result_q[$];
  result_t pred_r;
  result_t want_r;

  int mismatches;
  int bytes_sent;
  int msgs_sent;
  int beats_seen;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit take_word32(input logic [7:0] b, output logic [31:0] w);
    dfr_acc = {dfr_acc[55:0], b};
    dfr_idx = dfr_idx + 3'd1;
    w = dfr_acc[31:0];
    if (dfr_idx != LEN_WORD32) return 1'b0;
    dfr_idx = '0;
    dfr_acc = '0;
    return 1'b1;
  endfunction

  function automatic bit take_word64(input logic [7:0] b, output logic [63:0] w);
    dfr_acc = {dfr_acc[55:0], b};
    dfr_idx = dfr_idx + 3'd1;
    w = dfr_acc;
    if (dfr_idx != 3'd0) return 1'b0;
    dfr_acc = '0;
    return 1'b1;
  endfunction

  // advance the parser by one byte; returns 1 when a result beat is due
  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [31:0] w32;
    logic [63:0] w64;
    r = '0;
    case (dfr_phase)
      PH_MAGIC: begin
        if (take_word32(b, w32)) begin
          if (w32 != MAGIC_WORD) begin
            dfr_phase = PH_HALT;
            r = {K_BADMAGIC, 32'd0, w32, 1'b0};
            return 1'b1;
          end
          dfr_phase = PH_SIZE;
        end
      end
      PH_SIZE: begin
        if (take_word64(b, w64)) begin
          dfr_phase = PH_OPCODE;
          r = {K_SIZE, w64, 1'b0};
          return 1'b1;
        end
      end
      PH_OPCODE: begin
        dfr_phase = PH_PATHLEN;
        r = {K_OPCODE, 56'd0, b, 1'b0};
        return 1'b1;
      end
      PH_PATHLEN: begin
        if (take_word32(b, w32)) begin
          dfr_left  = w32;
          dfr_phase = (w32 == 32'd0) ? PH_BODYLEN : PH_PATH;
          r = {K_PATHLEN, 32'd0, w32, 1'b0};
          return 1'b1;
        end
      end
      PH_PATH: begin
        dfr_left = dfr_left - 32'd1;
        if (dfr_left == 32'd0) dfr_phase = PH_BODYLEN;
        r = {K_PATHBYTE, 56'd0, b, 1'b0};
        return 1'b1;
      end
      PH_BODYLEN: begin
        if (take_word32(b, w32)) begin
          dfr_left  = w32;
          dfr_phase = (w32 == 32'd0) ? PH_MTIME : PH_BODY;
          r = {K_BODYLEN, 32'd0, w32, 1'b0};
          return 1'b1;
        end
      end
      PH_BODY: begin
        dfr_left = dfr_left - 32'd1;
        if (dfr_left == 32'd0) dfr_phase = PH_MTIME;
        r = {K_BODYBYTE, 56'd0, b, 1'b0};
        return 1'b1;
      end
      PH_MTIME: begin
        if (take_word64(b, w64)) begin
          dfr_phase = PH_MAGIC;
          r = {K_MTIME, w64, 1'b1};
          return 1'b1;
        end
      end
      default: dfr_phase = PH_HALT;
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR @%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // byte in -> prediction; result beat out -> compare with oldest prediction
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (deframe_byte(in_ch.data_byte, pred_r)) result_q.insert(result_q.size(), pred_r);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_seen++;
      if (result_q.size() == 0) begin
        report_mismatch("unexpected beat, kind/value", {61'd0, out_ch.item_kind},
                        out_ch.item_value);
      end else begin
        want_r = result_q.pop_front();
        if (out_ch.item_kind !== want_r.kind)
          report_mismatch("item_kind", {61'd0, out_ch.item_kind}, {61'd0, want_r.kind});
        if (out_ch.item_value !== want_r.value)
          report_mismatch("item_value", out_ch.item_value, want_r.value);
        if (out_ch.message_end !== want_r.msg_end)
          report_mismatch("message_end", {63'd0, out_ch.message_end},
                          {63'd0, want_r.msg_end});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls plus an optional long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.data_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [63:0] w, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) send_byte(w[i*8 +: 8]);
  endtask

  // fill < 0 gives random payload bytes, otherwise every payload byte is fill
  task automatic send_message(input logic [63:0] total, input logic [7:0] op,
                              input int n_path, input int n_body,
                              input logic [63:0] mtime, input int fill);
    send_word({32'd0, MAGIC_WORD}, 4);
    send_word(total, 8);
    send_byte(op);
    send_word(64'(n_path), 4);
    for (int i = 0; i < n_path; i++)
      send_byte((fill < 0) ? 8'($urandom) : 8'(fill));
    send_word(64'(n_body), 4);
    for (int i = 0; i < n_body; i++)
      send_byte((fill < 0) ? 8'($urandom) : 8'(fill));
    send_word(mtime, 8);
    msgs_sent++;
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(6);
    if (r < 97) return $urandom_range(40, 7);
    return $urandom_range(300, 256);
  endfunction

  task automatic wait_drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_field_extremes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // zero lengths: no payload beats
    send_message(64'd0, 8'h00, 0, 0, 64'd0, 0);
    send_message('1, 8'hFF, 1, 1, '1, 8'hFF);
    send_message(64'h8000_0000_0000_0000, 8'h5A, 2, 0, 64'h8000_0000_0000_0000, 8'h00);
    send_message(64'h7FFF_FFFF_FFFF_FFFF, 8'hA5, 0, 2, 64'h7FFF_FFFF_FFFF_FFFF, 8'h55);
  endtask

  task automatic test_random_messages();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      // long stretch at full rate first, then random gaps on both sides
      if (bytes_sent - start < RANDOM_BYTES / 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 35;
        recv_idle_pct = 35;
      end
      send_message({$urandom, $urandom}, 8'($urandom), pick_len(), pick_len(),
                   {$urandom, $urandom}, -1);
    end
  endtask

  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_idle_pct = 35;
    stall_left = 300;
    send_message({$urandom, $urandom}, 8'($urandom), 12, 20, {$urandom, $urandom}, -1);
    send_message({$urandom, $urandom}, 8'($urandom), pick_len(), pick_len(),
                 {$urandom, $urandom}, -1);
  endtask

  // wrong magic halts the block for good, so this runs last
  task automatic test_bad_magic();
    send_idle_pct = 35;
    recv_idle_pct = 35;
    send_message({$urandom, $urandom}, 8'($urandom), 1, 1, {$urandom, $urandom}, -1);
    send_word({32'd0, MAGIC_WORD ^ 32'h0000_0001}, 4);
    // ignored while halted, including a good magic
    send_word({32'd0, MAGIC_WORD}, 4);
    for (int i = 0; i < 16; i++) send_byte(8'($urandom));
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    mismatches      = 0;
    bytes_sent      = 0;
    msgs_sent       = 0;
    beats_seen      = 0;
    cycle_count     = 0;
    stall_left      = 0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    dfr_phase       = PH_MAGIC;
    dfr_idx         = '0;
    dfr_acc         = '0;
    dfr_left        = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_field_extremes();
    test_random_messages();
    test_output_hold();
    test_bad_magic();
    wait_drain();

    $display("Covered %0d bytes in %0d messages with %0d result beats,", bytes_sent,
             msgs_sent, beats_seen);
    $display("field extremes, zero lengths, output hold-off and halt on wrong magic.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
